>>> hw/rtl/sfbts_pkg.sv
// Shared types and constants for the serial flash block transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none

package sfbts_pkg;

	localparam int unsigned PAGE_BYTES = 256;
	localparam int unsigned PAGE_BITS = $clog2(PAGE_BYTES);

	localparam logic [16:0] TOTAL_RESET = 17'd256;
	localparam logic [16:0] TOTAL_MAX = 17'h10000;

	typedef enum logic [2:0] {
		KIND_TICK = 3'd0,
		KIND_START_WRITE = 3'd1,
		KIND_START_READ = 3'd2,
		KIND_DMA_DONE = 3'd3,
		KIND_CONFIRM = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_WREN = 3'd1,
		CMD_ERASE = 3'd2,
		CMD_PROG = 3'd3,
		CMD_READ = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		PH_READY = 4'd0,
		PH_ERASE_WAIT = 4'd1,
		PH_ERASING = 4'd2,
		PH_WRITE_WAIT = 4'd3,
		PH_WRITING = 4'd4,
		PH_WRITE_DONE = 4'd5,
		PH_READ_WAIT = 4'd6,
		PH_READING = 4'd7,
		PH_READ_DONE = 4'd8
	} phase_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [7:0] block_number;
		logic [8:0] page_index;
		logic dma_in_flight;
		logic confirmed;
	} seq_state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [23:0] start_address;
		logic flash_busy;
		logic write_enable_latch;
	} item_t;

	typedef struct packed {
		logic [2:0] command;
		logic [23:0] command_address;
		logic [8:0] dma_length;
		logic [3:0] sequencer_state;
		logic accepted;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfbts_step.sv
// Next-state and result logic for one sequencer word.
`timescale 1ns / 1ps
`default_nettype none

module sfbts_step (
	input wire sfbts_pkg::seq_state_t st,
	input wire sfbts_pkg::item_t item,
	input wire [16:0] total_bytes,
	output sfbts_pkg::seq_state_t nxt,
	output sfbts_pkg::result_t res
);

	logic busy;
	logic [8:0] pages;
	logic [7:0] rest;
	logic in_write;
	logic [2:0] page_cmd;
	logic [3:0] wait_phase;
	logic [3:0] done_phase;

	assign busy = st.dma_in_flight | item.flash_busy;
	assign pages = total_bytes[16:sfbts_pkg::PAGE_BITS];
	assign rest = total_bytes[sfbts_pkg::PAGE_BITS-1:0];
	assign in_write = (st.phase == sfbts_pkg::PH_WRITING);
	assign page_cmd = in_write ? sfbts_pkg::CMD_PROG : sfbts_pkg::CMD_READ;
	assign wait_phase = in_write ? sfbts_pkg::PH_WRITE_WAIT : sfbts_pkg::PH_READ_WAIT;
	assign done_phase = in_write ? sfbts_pkg::PH_WRITE_DONE : sfbts_pkg::PH_READ_DONE;

	always_comb begin
		nxt = st;
		res.command = sfbts_pkg::CMD_NONE;
		res.command_address = 24'd0;
		res.dma_length = 9'd0;
		res.accepted = 1'b0;
		case (item.kind)
			sfbts_pkg::KIND_TICK: begin
				case (st.phase)
					sfbts_pkg::PH_READY: begin
					end
					sfbts_pkg::PH_ERASE_WAIT: begin
						if (!item.flash_busy && item.write_enable_latch) begin
							res.command = sfbts_pkg::CMD_ERASE;
							res.command_address = {st.block_number, 16'd0};
							nxt.phase = sfbts_pkg::PH_ERASING;
						end else begin
							res.command = sfbts_pkg::CMD_WREN;
						end
					end
					sfbts_pkg::PH_ERASING: begin
						if (!busy) nxt.phase = sfbts_pkg::PH_WRITE_WAIT;
					end
					sfbts_pkg::PH_WRITE_WAIT: begin
						if (!busy) begin
							res.command = sfbts_pkg::CMD_WREN;
							if (item.write_enable_latch) nxt.phase = sfbts_pkg::PH_WRITING;
						end
					end
					sfbts_pkg::PH_WRITING, sfbts_pkg::PH_READING: begin
						if (st.page_index <= pages) begin
							res.command = page_cmd;
							res.command_address = {st.block_number, 16'd0}
								| {7'd0, st.page_index, 8'd0};
							res.dma_length = (st.page_index < pages) ? 9'd256 : {1'b0, rest};
							nxt.page_index = st.page_index + 9'd1;
							nxt.dma_in_flight = 1'b1;
							nxt.phase = wait_phase;
						end else if (!busy) begin
							nxt.phase = done_phase;
						end
					end
					sfbts_pkg::PH_WRITE_DONE, sfbts_pkg::PH_READ_DONE: begin
						if (st.confirmed) nxt.phase = sfbts_pkg::PH_READY;
					end
					sfbts_pkg::PH_READ_WAIT: begin
						if (!busy) nxt.phase = sfbts_pkg::PH_READING;
					end
					default: begin
						nxt.phase = sfbts_pkg::PH_READY;
					end
				endcase
			end
			sfbts_pkg::KIND_START_WRITE, sfbts_pkg::KIND_START_READ: begin
				if (st.phase == sfbts_pkg::PH_READY) begin
					nxt.block_number = item.start_address[23:16];
					nxt.page_index = 9'd0;
					nxt.confirmed = 1'b0;
					nxt.phase = (item.kind == sfbts_pkg::KIND_START_WRITE)
						? sfbts_pkg::PH_ERASE_WAIT : sfbts_pkg::PH_READ_WAIT;
					res.accepted = 1'b1;
				end
			end
			sfbts_pkg::KIND_DMA_DONE: begin
				nxt.dma_in_flight = 1'b0;
			end
			sfbts_pkg::KIND_CONFIRM: begin
				if (!busy) nxt.confirmed = 1'b1;
			end
			default: begin
			end
		endcase
		res.sequencer_state = nxt.phase;
	end

endmodule

`default_nettype wire

>>> hw/rtl/serial_flash_block_transfer_sequencer_core.sv
// Top level of the serial flash block transfer sequencer.
//
// Input channel (in_valid/in_ready) carries one event word: a tick with the
// sampled flash status bits, a start-write or start-read request, a dma-done
// or a confirm. Each input word yields exactly one result word on the output
// channel (out_valid/out_ready): the command to issue, its address, the DMA
// length, the sequencer phase after the event and a start-accepted flag.
// The word is held in an input register, then the step logic updates the
// sequencer state and loads the result register. Throughput is one word
// per cycle while the receiver takes results, set by the combinational
// step logic and the state registers it feeds back into.
// The cfg channel (cfg_valid/cfg_ready) writes total_bytes; it is always
// ready, saturates values above 65536 and must be used only while idle.
// Reset clears the phase to ready, the counters and flags, and sets
// total_bytes to 256. When the receiver stalls, the result register holds,
// the input register fills and in_ready drops; no word is lost.
`timescale 1ns / 1ps
`default_nettype none

module serial_flash_block_transfer_sequencer_core (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input wire [2:0] kind,
	input wire [23:0] start_address,
	input wire flash_busy,
	input wire write_enable_latch,
	output logic out_valid,
	input wire out_ready,
	output logic [2:0] command,
	output logic [23:0] command_address,
	output logic [8:0] dma_length,
	output logic [3:0] sequencer_state,
	output logic accepted,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire [16:0] total_bytes
);

	logic valid_s1;
	sfbts_pkg::item_t item_s1;
	logic advance;
	sfbts_pkg::seq_state_t state_q;
	sfbts_pkg::seq_state_t state_nxt;
	sfbts_pkg::result_t res_nxt;
	sfbts_pkg::result_t res_q;
	logic [16:0] total_q;

	assign advance = valid_s1 & (~out_valid | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{kind: kind, start_address: start_address,
				flash_busy: flash_busy, write_enable_latch: write_enable_latch};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= sfbts_pkg::TOTAL_RESET;
		end else if (cfg_valid) begin
			total_q <= (total_bytes > sfbts_pkg::TOTAL_MAX) ? sfbts_pkg::TOTAL_MAX : total_bytes;
		end
	end

	sfbts_step u_step (
		.st(state_q),
		.item(item_s1),
		.total_bytes(total_q),
		.nxt(state_nxt),
		.res(res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (~out_valid | out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign command = res_q.command;
	assign command_address = res_q.command_address;
	assign dma_length = res_q.dma_length;
	assign sequencer_state = res_q.sequencer_state;
	assign accepted = res_q.accepted;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for the serial flash block transfer sequencer core.
`timescale 1ns / 1ps

module tb_top;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	class flash_sequence_check;
		sfbts_pkg::phase_t ph;
		logic [7:0] blk;
		logic [8:0] page;
		bit dma_on;
		bit conf_set;
		logic [16:0] total;
		sfbts_pkg::result_t due_steps[$];
		int errors;

		function new();
			ph = sfbts_pkg::PH_READY;
			blk = '0;
			page = '0;
			dma_on = 0;
			conf_set = 0;
			total = sfbts_pkg::TOTAL_RESET;
			errors = 0;
		endfunction

		function void set_total(logic [16:0] v);
			total = (v > sfbts_pkg::TOTAL_MAX) ? sfbts_pkg::TOTAL_MAX : v;
		endfunction

		function void page_step(sfbts_pkg::cmd_t op, sfbts_pkg::phase_t wait_ph,
				sfbts_pkg::phase_t done_ph, bit busy, inout sfbts_pkg::result_t r);
			logic [8:0] pages;
			pages = total[16:8];
			if (page <= pages) begin
				r.command = op;
				r.command_address = {blk, 16'h0} | {7'h0, page, 8'h0};
				r.dma_length = (page < pages) ? 9'(sfbts_pkg::PAGE_BYTES)
					: {1'b0, total[7:0]};
				page = page + 9'd1;
				dma_on = 1;
				ph = wait_ph;
			end else if (!busy) begin
				ph = done_ph;
			end
		endfunction

		function void note_event(sfbts_pkg::item_t e);
			sfbts_pkg::result_t r;
			bit busy;
			r = '0;
			busy = dma_on || e.flash_busy;
			case (e.kind)
				sfbts_pkg::KIND_TICK: begin
					case (ph)
						sfbts_pkg::PH_READY: ;
						sfbts_pkg::PH_ERASE_WAIT: begin
							if (!e.flash_busy && e.write_enable_latch) begin
								r.command = sfbts_pkg::CMD_ERASE;
								r.command_address = {blk, 16'h0};
								ph = sfbts_pkg::PH_ERASING;
							end else begin
								r.command = sfbts_pkg::CMD_WREN;
							end
						end
						sfbts_pkg::PH_ERASING: if (!busy) ph = sfbts_pkg::PH_WRITE_WAIT;
						sfbts_pkg::PH_WRITE_WAIT: begin
							if (!busy) begin
								r.command = sfbts_pkg::CMD_WREN;
								if (e.write_enable_latch) ph = sfbts_pkg::PH_WRITING;
							end
						end
						sfbts_pkg::PH_WRITING: begin
							page_step(sfbts_pkg::CMD_PROG, sfbts_pkg::PH_WRITE_WAIT,
								sfbts_pkg::PH_WRITE_DONE, busy, r);
						end
						sfbts_pkg::PH_WRITE_DONE, sfbts_pkg::PH_READ_DONE: begin
							if (conf_set) ph = sfbts_pkg::PH_READY;
						end
						sfbts_pkg::PH_READ_WAIT: if (!busy) ph = sfbts_pkg::PH_READING;
						sfbts_pkg::PH_READING: begin
							page_step(sfbts_pkg::CMD_READ, sfbts_pkg::PH_READ_WAIT,
								sfbts_pkg::PH_READ_DONE, busy, r);
						end
						default: ph = sfbts_pkg::PH_READY;
					endcase
				end
				sfbts_pkg::KIND_START_WRITE, sfbts_pkg::KIND_START_READ: begin
					if (ph == sfbts_pkg::PH_READY) begin
						blk = e.start_address[23:16];
						page = '0;
						conf_set = 0;
						if (e.kind == sfbts_pkg::KIND_START_WRITE)
							ph = sfbts_pkg::PH_ERASE_WAIT;
						else
							ph = sfbts_pkg::PH_READ_WAIT;
						r.accepted = 1'b1;
					end
				end
				sfbts_pkg::KIND_DMA_DONE: dma_on = 0;
				sfbts_pkg::KIND_CONFIRM: if (!busy) conf_set = 1;
				default: ;
			endcase
			r.sequencer_state = ph;
			due_steps.push_back(r);
		endfunction

		function void check_step(sfbts_pkg::result_t got);
			sfbts_pkg::result_t want;
			if (due_steps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result word with nothing outstanding: %s %0d %06h %0d %0d %0d",
						"cmd addr len st acc", got.command, got.command_address,
						got.dma_length, got.sequencer_state, got.accepted);
				return;
			end
			want = due_steps.pop_front();
			if (got.command !== want.command ||
					got.command_address !== want.command_address ||
					got.dma_length !== want.dma_length ||
					got.sequencer_state !== want.sequencer_state ||
					got.accepted !== want.accepted) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: cmd %0d/%0d addr %06h/%06h len %0d/%0d",
						" st %0d/%0d acc %0d/%0d"},
						want.command, got.command, want.command_address,
						got.command_address, want.dma_length, got.dma_length,
						want.sequencer_state, got.sequencer_state,
						want.accepted, got.accepted);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] kind;
	logic [23:0] start_address;
	logic flash_busy;
	logic write_enable_latch;
	logic out_valid;
	logic out_ready;
	logic [2:0] command;
	logic [23:0] command_address;
	logic [8:0] dma_length;
	logic [3:0] sequencer_state;
	logic accepted;
	logic cfg_valid;
	logic cfg_ready;
	logic [16:0] total_bytes;

	flash_sequence_check sb = new();

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_seen;
	int hold_left;
	int stalled_cycles;

	serial_flash_block_transfer_sequencer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.start_address(start_address),
		.flash_busy(flash_busy),
		.write_enable_latch(write_enable_latch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.command(command),
		.command_address(command_address),
		.dma_length(dma_length),
		.sequencer_state(sequencer_state),
		.accepted(accepted),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.total_bytes(total_bytes)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_step(sfbts_pkg::result_t'{command, command_address, dma_length,
				sequencer_state, accepted});
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic sfbts_pkg::item_t ev(logic [2:0] k, logic [23:0] a, bit fb, bit wl);
		sfbts_pkg::item_t e;
		e.kind = k;
		e.start_address = a;
		e.flash_busy = fb;
		e.write_enable_latch = wl;
		return e;
	endfunction

	function automatic sfbts_pkg::item_t pick_event(int noise_pct, bit eager);
		sfbts_pkg::item_t e;
		e = ev(sfbts_pkg::KIND_TICK, 24'($urandom_range(24'hFFFFFF)),
			eager ? 1'b0 : ($urandom_range(99) < 25),
			eager ? 1'b1 : ($urandom_range(99) < 80));
		if (!eager && $urandom_range(99) < noise_pct) begin
			e.kind = 3'($urandom_range(7));
			return e;
		end
		case (sb.ph)
			sfbts_pkg::PH_READY: begin
				e.kind = $urandom_range(1) ? sfbts_pkg::KIND_START_WRITE
					: sfbts_pkg::KIND_START_READ;
			end
			sfbts_pkg::PH_ERASING, sfbts_pkg::PH_WRITE_WAIT, sfbts_pkg::PH_READ_WAIT: begin
				if (sb.dma_on) e.kind = sfbts_pkg::KIND_DMA_DONE;
			end
			sfbts_pkg::PH_WRITE_DONE, sfbts_pkg::PH_READ_DONE: begin
				if (!sb.conf_set) e.kind = sfbts_pkg::KIND_CONFIRM;
			end
			default: ;
		endcase
		return e;
	endfunction

	task automatic send_event(sfbts_pkg::item_t e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= e.kind;
		start_address <= e.start_address;
		flash_busy <= e.flash_busy;
		write_enable_latch <= e.write_enable_latch;
		do @(posedge clk); while (!in_ready);
		sb.note_event(e);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_steps.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_total(logic [16:0] v);
		drain();
		cfg_valid <= 1'b1;
		total_bytes <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_total(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_mixed(int count);
		repeat (count) send_event(pick_event(15, 1'b0));
	endtask

	task automatic settle();
		while (sb.ph != sfbts_pkg::PH_READY) send_event(pick_event(0, 1'b1));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = sfbts_pkg::KIND_TICK;
		start_address = '0;
		flash_busy = 1'b0;
		write_enable_latch = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		total_bytes = '0;
		send_idle_pct = 38;
		recv_idle_pct = 86;
		hold_requests = 0;
		hold_seen = 0;
		hold_left = 0;
		stalled_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_CONFIRM, 24'h000000, 1'b0, 1'b0));
		for (int k = sfbts_pkg::KIND_CONFIRM + 1; k < 8; k++)
			send_event(ev(3'(k), 24'hFFFFFF, 1'b1, 1'b1));
		send_event(ev(sfbts_pkg::KIND_DMA_DONE, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_START_WRITE, 24'hFFFFFF, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_START_READ, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b1, 1'b1));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b1));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b1, 1'b0));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b1));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b1));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b1));
		send_event(ev(sfbts_pkg::KIND_CONFIRM, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_DMA_DONE, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b1));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b1));
		send_event(ev(sfbts_pkg::KIND_DMA_DONE, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b1));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b1, 1'b1));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_CONFIRM, 24'h000000, 1'b0, 1'b0));
		send_event(ev(sfbts_pkg::KIND_TICK, 24'h000000, 1'b0, 1'b0));

		run_mixed(30);
		write_total(17'd0);
		run_mixed(30);
		write_total(17'd1);
		run_mixed(30);
		write_total(17'd255);
		run_mixed(30);

		send_idle_pct = 86;
		recv_idle_pct = 38;
		write_total(17'd257);
		hold_requests++;
		run_mixed(30);
		write_total(17'd511);
		run_mixed(20);
		write_total(17'($urandom_range(1023)));
		run_mixed(20);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		settle();
		write_total(17'h1FFFF);
		send_event(ev(sfbts_pkg::KIND_START_READ, 24'($urandom_range(24'hFFFFFF)),
			1'b0, 1'b0));
		settle();
		write_total(17'd65535);
		run_mixed(20);
		write_total(17'd65536);
		run_mixed(20);
		write_total(17'($urandom_range(600)));
		run_mixed(20);

		drain();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.due_steps.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> serial_flash_block_transfer_sequencer_core.f
hw/rtl/sfbts_pkg.sv
hw/rtl/sfbts_step.sv
hw/rtl/serial_flash_block_transfer_sequencer_core.sv
tb/sv/tb_top.sv
